[design/best_fit_heap_allocator_defines.svh]
// assertion helpers used by best_fit_heap_allocator
`ifndef BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// condition must hold at every edge outside reset
`define BFHA_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");

// antecedent implies consequent in the same cycle
`define BFHA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

// antecedent implies consequent in the next cycle
`define BFHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

[design/bfha_pkg.sv]
package bfha_pkg;

  localparam int DEF_POOL_BYTES   = 65536;
  localparam int DEF_HEADER_BYTES = 24;
  localparam int GRANULE_BYTES    = 8;
  localparam int GRANULE_SHIFT    = 3;
  localparam int NEED_W           = 18;
  localparam int SIZE_W           = 17;
  localparam int OFFSET_W         = 16;
  localparam int USED_W           = 17;
  localparam int STATUS_W         = 2;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 2'd0,
    STS_NULL    = 2'd1,
    STS_NO_FIT  = 2'd2,
    STS_BAD     = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_MRG_LD,
    S_MRG_CHK,
    S_MRG_NX,
    S_SR_RD,
    S_SR_LD,
    S_SR_END,
    S_AL_SPLIT,
    S_AL_BEST,
    S_AL_PREV,
    S_FR_LD,
    S_FR_WALK,
    S_FR_WLD,
    S_FR_SELF,
    S_FR_PREV,
    S_DONE
  } state_t;

endpackage

[design/bfha_mem.sv]
module bfha_mem #(
  parameter int DEPTH = 8192,
  parameter int WW    = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WW-1:0]            rdata
);
  import bfha_pkg::*;

  logic [WW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/best_fit_heap_allocator.sv]
// channel   dir  handshake             word
// --------  ---  --------------------  ------------------------------------------
// request   in   in_valid / in_stall   func, req_size, release_offset
// result    out  out_valid / out_stall payload_offset, status, bytes_in_use
//
// after reset a clearing pass writes every header entry
// allocate: merge free neighbours, best-fit search, split if room, header writes
// free: walk the free blocks below the released one, then header writes
// a refused free writes nothing; all accesses use the single header memory
// one request at a time; the next request is taken while the result waits
module best_fit_heap_allocator #(
  parameter int POOL_BYTES   = bfha_pkg::DEF_POOL_BYTES,
  parameter int HEADER_BYTES = bfha_pkg::DEF_HEADER_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          func,
  input  logic [bfha_pkg::SIZE_W-1:0]   req_size,
  input  logic [bfha_pkg::OFFSET_W-1:0] release_offset,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bfha_pkg::OFFSET_W-1:0] payload_offset,
  output logic [bfha_pkg::STATUS_W-1:0] status,
  output logic [bfha_pkg::USED_W-1:0]   bytes_in_use
);
  import bfha_pkg::*;

`include "best_fit_heap_allocator_defines.svh"

  // geometry
  localparam int DEPTH = POOL_BYTES / GRANULE_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = AW + 1;
  localparam int LW    = $clog2(POOL_BYTES + 1);
  localparam int WW    = 1 + IW + LW;
  localparam int CW    = ((LW > NEED_W) ? LW : NEED_W) + 2;
  localparam logic [IW-1:0] NIL = IW'(DEPTH);

  // header word: free flag, link, payload length
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [WW-1:0] rdata;

  logic          rd_free;
  logic [IW-1:0] rd_link;
  logic [LW-1:0] rd_len;

  state_t state, state_next;

  logic [AW-1:0]     clr_cnt;
  logic [NEED_W-1:0] need;
  logic [IW-1:0]     head;
  logic [LW-1:0]     used;
  logic [IW-1:0]     cur;
  logic [LW-1:0]     cur_len;
  logic [IW-1:0]     cur_link;
  logic              dirty;
  logic [IW-1:0]     prv;
  logic [LW-1:0]     prv_len;
  logic [IW-1:0]     best;
  logic [IW-1:0]     best_prv;
  logic [LW-1:0]     best_prv_len;
  logic [LW-1:0]     best_len;
  logic [IW-1:0]     best_link;
  logic [LW-1:0]     best_slack;
  logic              found;
  logic [OFFSET_W-1:0] res_offset;
  status_t           res_status;

  bfha_mem #(
    .DEPTH (DEPTH),
    .WW    (WW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  assign rd_free = rdata[WW-1];
  assign rd_link = rdata[LW+IW-1:LW];
  assign rd_len  = rdata[LW-1:0];

  // shared arithmetic
  logic          acc_in;
  logic          out_free;
  logic [CW-1:0] hdr_c;
  logic [NEED_W-1:0] need_in;
  logic          zero_req;
  logic          adj;
  logic [CW-1:0] diff_c;
  logic          fits;
  logic          better;
  logic          exact;
  logic          split;
  logic [CW-1:0] nb_c;
  logic [CW-1:0] off_c;
  logic [CW-1:0] rel_c;
  logic [CW-1:0] idx_c;
  logic          fr_null;
  logic          fr_bad;
  logic          walk_stop;
  logic [CW-1:0] sz_c;
  logic [CW-1:0] grant_c;

  assign acc_in   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign hdr_c    = CW'(HEADER_BYTES);
  assign need_in  = (NEED_W'(req_size) + NEED_W'(7)) & ~NEED_W'(7);
  assign zero_req = (req_size == '0);

  // next block starts right where the current one ends
  assign adj = ((CW'(cur) << GRANULE_SHIFT) + hdr_c + CW'(cur_len)) ==
               (CW'(cur_link) << GRANULE_SHIFT);

  assign diff_c = CW'(rd_len) - CW'(need);
  assign fits   = rd_free && (CW'(rd_len) >= CW'(need));
  assign better = fits && (!found || (diff_c < CW'(best_slack)));
  assign exact  = better && (diff_c == '0);

  assign split  = CW'(best_len) >= (CW'(need) + hdr_c + CW'(GRANULE_BYTES));
  assign nb_c   = CW'(best) + ((hdr_c + CW'(need)) >> GRANULE_SHIFT);

  assign off_c   = CW'(release_offset);
  assign rel_c   = off_c - hdr_c;
  assign idx_c   = rel_c >> GRANULE_SHIFT;
  assign fr_null = (release_offset == '0);
  assign fr_bad  = (off_c < hdr_c) || (rel_c[GRANULE_SHIFT-1:0] != '0) ||
                   (idx_c >= CW'(DEPTH));

  assign walk_stop = (cur == NIL) || (cur >= best);
  assign sz_c      = CW'(rd_len) + hdr_c;
  assign grant_c   = (CW'(best) << GRANULE_SHIFT) + hdr_c;

  assign in_stall = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == AW'(DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (acc_in) begin
          if (func == FUNC_FREE) begin
            state_next = (fr_null || fr_bad) ? S_DONE : S_FR_LD;
          end else if (zero_req) begin
            state_next = S_DONE;
          end else if (head == NIL) begin
            state_next = S_SR_RD;
          end else begin
            state_next = S_MRG_LD;
          end
        end
      end
      S_MRG_LD:  state_next = S_MRG_CHK;
      S_MRG_CHK: state_next = (cur_link == NIL) ? S_SR_RD : S_MRG_NX;
      S_MRG_NX:  state_next = S_MRG_CHK;
      S_SR_RD:   state_next = (cur == NIL) ? S_SR_END : S_SR_LD;
      S_SR_LD: begin
        if (exact || (rd_link == NIL)) state_next = S_SR_END;
      end
      S_SR_END: begin
        if (!found)     state_next = S_DONE;
        else if (split) state_next = S_AL_SPLIT;
        else            state_next = S_AL_BEST;
      end
      S_AL_SPLIT: state_next = S_AL_BEST;
      S_AL_BEST:  state_next = S_AL_PREV;
      S_AL_PREV:  state_next = S_DONE;
      S_FR_LD:    state_next = rd_free ? S_DONE : S_FR_WALK;
      S_FR_WALK:  state_next = walk_stop ? S_FR_SELF : S_FR_WLD;
      S_FR_WLD:   state_next = S_FR_WALK;
      S_FR_SELF:  state_next = S_FR_PREV;
      S_FR_PREV:  state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default:    state_next = S_CLEAR;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur[AW-1:0];
    mem_wdata = {1'b1, cur_link, cur_len};
    mem_re    = 1'b0;
    mem_raddr = cur[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = {1'b1, NIL,
                     (clr_cnt == '0) ? LW'(POOL_BYTES - HEADER_BYTES) : LW'(0)};
      end
      S_IDLE: begin
        if (acc_in && (func == FUNC_FREE) && !fr_null && !fr_bad) begin
          mem_re    = 1'b1;
          mem_raddr = idx_c[AW-1:0];
        end else if (acc_in && (func == FUNC_ALLOC) && !zero_req && (head != NIL)) begin
          mem_re    = 1'b1;
          mem_raddr = head[AW-1:0];
        end
      end
      S_MRG_CHK: begin
        if (cur_link == NIL) begin
          mem_we = dirty;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cur_link[AW-1:0];
        end
      end
      S_MRG_NX: begin
        mem_we = !adj && dirty;
      end
      S_SR_RD: begin
        mem_re = (cur != NIL);
      end
      S_SR_LD: begin
        mem_re    = !exact && (rd_link != NIL);
        mem_raddr = rd_link[AW-1:0];
      end
      S_AL_SPLIT: begin
        mem_we    = 1'b1;
        mem_wdata = {1'b1, best_link, LW'(CW'(best_len) - CW'(need) - hdr_c)};
      end
      S_AL_BEST: begin
        mem_we    = 1'b1;
        mem_waddr = best[AW-1:0];
        mem_wdata = {1'b0, best_link, best_len};
      end
      S_AL_PREV: begin
        mem_we    = (best_prv != NIL);
        mem_waddr = best_prv[AW-1:0];
        mem_wdata = {1'b1, cur, best_prv_len};
      end
      S_FR_WALK: begin
        mem_re = !walk_stop;
      end
      S_FR_SELF: begin
        mem_we    = 1'b1;
        mem_waddr = best[AW-1:0];
        mem_wdata = {1'b1, cur, best_len};
      end
      S_FR_PREV: begin
        mem_we    = (prv != NIL);
        mem_waddr = prv[AW-1:0];
        mem_wdata = {1'b1, best, prv_len};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      head    <= '0;
      used    <= '0;
      dirty   <= 1'b0;
      found   <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
        end
        S_IDLE: begin
          if (acc_in) begin
            res_offset <= '0;
            need       <= need_in;
            cur        <= head;
            prv        <= NIL;
            found      <= 1'b0;
            best       <= IW'(idx_c);
            if (func == FUNC_FREE) begin
              if (fr_null)     res_status <= STS_NULL;
              else if (fr_bad) res_status <= STS_BAD;
            end else if (zero_req) begin
              res_status <= STS_NULL;
            end
          end
        end
        S_MRG_LD: begin
          cur_len  <= rd_len;
          cur_link <= rd_link;
          dirty    <= 1'b0;
        end
        S_MRG_CHK: begin
          if (cur_link == NIL) begin
            // merging done, restart at the head for the search
            cur   <= head;
            prv   <= NIL;
            found <= 1'b0;
          end
        end
        S_MRG_NX: begin
          if (adj) begin
            cur_len  <= LW'(CW'(cur_len) + hdr_c + CW'(rd_len));
            cur_link <= rd_link;
            dirty    <= 1'b1;
          end else begin
            cur      <= cur_link;
            cur_len  <= rd_len;
            cur_link <= rd_link;
            dirty    <= 1'b0;
          end
        end
        S_SR_LD: begin
          if (better) begin
            found        <= 1'b1;
            best_slack   <= LW'(diff_c);
            best         <= cur;
            best_prv     <= prv;
            best_prv_len <= prv_len;
            best_len     <= rd_len;
            best_link    <= rd_link;
          end
          if (!exact) begin
            prv     <= cur;
            prv_len <= rd_len;
            cur     <= rd_link;
          end
        end
        S_SR_END: begin
          if (!found) res_status <= STS_NO_FIT;
          else        cur        <= split ? IW'(nb_c) : best_link;
        end
        S_AL_SPLIT: begin
          best_len <= LW'(need);
        end
        S_AL_BEST: begin
          used <= LW'(CW'(used) + CW'(best_len) + hdr_c);
        end
        S_AL_PREV: begin
          if (best_prv == NIL) head <= cur;
          res_status <= STS_OK;
          res_offset <= OFFSET_W'(grant_c);
        end
        S_FR_LD: begin
          if (rd_free) begin
            res_status <= STS_BAD;
          end else begin
            best_len <= rd_len;
            used     <= (CW'(used) >= sz_c) ? LW'(CW'(used) - sz_c) : '0;
            cur      <= head;
            prv      <= NIL;
          end
        end
        S_FR_WLD: begin
          prv     <= cur;
          prv_len <= rd_len;
          cur     <= rd_link;
        end
        S_FR_PREV: begin
          if (prv == NIL) head <= best;
          res_status <= STS_OK;
        end
        default: begin
        end
      endcase
    end
  end

  // output register, parts the result side from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid      <= 1'b1;
      payload_offset <= res_offset;
      status         <= res_status;
      bytes_in_use   <= USED_W'(used);
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // checks
  `BFHA_ASSERT_ALWAYS(a_used_bound, used <= LW'(POOL_BYTES))
  `BFHA_ASSERT_IMPL(a_head_range, state == S_IDLE, head <= NIL)
  `BFHA_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state != S_IDLE)
  `BFHA_ASSERT_NEXT(a_done_delivers, (state == S_DONE) && (!out_valid || !out_stall), out_valid && (state == S_IDLE))

endmodule
